@@ src/lfu_cache_table_assert.svh @@
// Assertion macros for the cache table RTL.
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define LFU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/lfu_pkg.sv @@
// Shared constants, controller states and controller interface structs.
`default_nettype none

package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 31;
  localparam int COUNT_W = 16;
  localparam int LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_PLAN,
    S_SWEEP,
    S_SWEEP_END,
    S_DONE
  } lfu_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic idle;       // ready for a new input beat
    logic load_item;  // capture the input beat, clear scan accumulators
    logic issue;      // read the table at the issue pointer and advance it
    logic sweep;      // reads belong to the write-back pass
    logic plan;       // register the decision taken from the scan
    logic finish;     // load the output register
  } lfu_ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_valid;
    logic iss_last;
    logic need_sweep;
    logic out_free;
  } lfu_stat_t;

endpackage

`default_nettype wire

@@ src/lfu_entry_ram.sv @@
// Entry table memory: one write port, one registered read port.
`default_nettype none

module lfu_entry_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 83,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/lfu_ctrl.sv @@
// Sequencer: scan pass, decision, write-back pass, result hand-off.
`default_nettype none

module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire lfu_stat_t st,
  output      lfu_ctrl_t ctl
);

  lfu_state_t state;
  lfu_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        ctl.idle = 1'b1;
        if (st.in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.issue = 1'b1;
        if (st.iss_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_PLAN;
      end
      S_PLAN: begin
        ctl.plan   = 1'b1;
        state_next = st.need_sweep ? S_SWEEP : S_DONE;
      end
      S_SWEEP: begin
        ctl.issue = 1'b1;
        ctl.sweep = 1'b1;
        if (st.iss_last) begin
          state_next = S_SWEEP_END;
        end
      end
      S_SWEEP_END: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/lfu_cache_table.sv @@
// Top level: LFU key/value cache with LRU tie-break over a flat entry table.
//
// Input channel (in_valid / in_stall): one beat carries command (0 get,
// 1 put), lookup_key and store_value. Output channel (out_valid /
// out_stall): exactly one beat per input beat with hit, read_value and
// evicted, in input order. Configuration channel (cfg_valid / cfg_ready)
// writes live_limit; write it only while the cache is idle.
// Each item first scans all CAPACITY table entries through the memory's
// one read port (one entry per cycle) to find the key, the victim and the
// lowest free slot. If the item changes state, a second pass reads every
// entry again and writes back count, rank, key and value one entry a cycle.
// The result follows the scan, the decision and, where needed, the write-back
// pass; a new beat is taken only once the previous item has handed its result
// to the output register. The write-back pass ends before the next scan can
// issue, so reads never race a pending write.
// Reset empties the cache (valid bits cleared, no memory sweep) and sets
// live_limit to 16. While the receiver stalls, the result is held in the
// output register; the next item is still accepted and worked on, and it
// waits in its last state until the output register frees up.
`default_nettype none
`include "lfu_cache_table_assert.svh"

module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input beats
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               command,
  input  wire logic [KEY_W-1:0]   lookup_key,
  input  wire logic [VAL_W-1:0]   store_value,
  // result beats
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic               hit,
  output      logic [VAL_W-1:0]   read_value,
  output      logic               evicted,
  // live_limit write port
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_live_limit
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W = IDX_W;
  localparam int USED_W = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (USED_W > LIMIT_W) ? USED_W : LIMIT_W;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic [RANK_W-1:0]  rank;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  lfu_ctrl_t ctl;
  lfu_stat_t st;

  // live limit register
  logic [LIMIT_W-1:0] live_limit;

  // captured item
  logic             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // read issue pointer and the beat returning from memory
  logic [IDX_W-1:0] iss;
  logic             beat_vld;
  logic             beat_sweep;
  logic [IDX_W-1:0] beat_idx;

  // per-entry valid bits
  logic [CAPACITY-1:0] vld;
  logic                bv;

  // scan accumulators
  logic [USED_W-1:0]  used;
  logic               found;
  logic [IDX_W-1:0]   f_idx;
  logic [VAL_W-1:0]   f_val;
  logic [RANK_W-1:0]  f_rank;
  logic               vic_any;
  logic [IDX_W-1:0]   vic_idx;
  logic [COUNT_W-1:0] vic_cnt;
  logic [RANK_W-1:0]  vic_rank;
  logic               free_any;
  logic [IDX_W-1:0]   free_idx;

  // decision
  logic             lim_ok;
  logic [CMP_W-1:0] lim_x;
  logic [CMP_W-1:0] cap_x;
  logic [CMP_W-1:0] eff_limit;
  logic             evict_now;
  logic             ins_now;
  logic             bump_now;
  logic [IDX_W-1:0] slot_now;

  logic             p_bump;
  logic             p_ins;
  logic             p_evict;
  logic [IDX_W-1:0] p_slot;
  logic             p_hit;
  logic [VAL_W-1:0] p_rd;
  logic             p_ev;

  // memory ports
  logic [ENT_W-1:0] ram_rd_data;
  entry_t           rd_ent;
  entry_t           wr_ent;
  logic             wr_en;
  logic             vld_set;
  logic             vld_clr;
  logic             rank_dec;

  lfu_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .ctl (ctl)
  );

  lfu_entry_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (ENT_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ctl.issue),
    .rd_addr (iss),
    .rd_data (ram_rd_data),
    .wr_en   (wr_en),
    .wr_addr (beat_idx),
    .wr_data (wr_ent)
  );

  assign rd_ent = ram_rd_data;

  // Handshakes. Hold off both channels while reset is applied.
  assign in_stall  = rst || !ctl.idle;
  assign cfg_ready = !rst;

  assign st.in_valid   = in_valid;
  assign st.iss_last   = (iss == IDX_W'(CAPACITY - 1));
  assign st.need_sweep = bump_now || ins_now;
  assign st.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      live_limit <= cfg_live_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_q <= command;
      key_q <= lookup_key;
      val_q <= store_value;
    end
  end

  // Issue pointer restarts for each pass; every issued read comes back as
  // a beat in the next cycle, tagged with its index and pass.
  always_ff @(posedge clk) begin
    if (rst || ctl.load_item || ctl.plan) begin
      iss <= '0;
    end else if (ctl.issue) begin
      iss <= iss + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_vld   <= 1'b0;
      beat_sweep <= 1'b0;
    end else begin
      beat_vld   <= ctl.issue;
      beat_sweep <= ctl.sweep;
    end
    beat_idx <= iss;
  end

  assign bv = vld[beat_idx];

  // Scan pass: count live entries, find the first key match, track the
  // victim (lowest count, then oldest) and the lowest free slot.
  always_ff @(posedge clk) begin
    if (rst || ctl.load_item) begin
      used     <= '0;
      found    <= 1'b0;
      vic_any  <= 1'b0;
      free_any <= 1'b0;
    end else if (beat_vld && !beat_sweep) begin
      if (bv) begin
        used <= used + USED_W'(1);
        if (!found && rd_ent.key == key_q) begin
          found  <= 1'b1;
          f_idx  <= beat_idx;
          f_val  <= rd_ent.value;
          f_rank <= rd_ent.rank;
        end
        if (!vic_any || rd_ent.count < vic_cnt ||
            (rd_ent.count == vic_cnt && rd_ent.rank > vic_rank)) begin
          vic_any  <= 1'b1;
          vic_idx  <= beat_idx;
          vic_cnt  <= rd_ent.count;
          vic_rank <= rd_ent.rank;
        end
      end else if (!free_any) begin
        free_any <= 1'b1;
        free_idx <= beat_idx;
      end
    end
  end

  // Decision from the finished scan. A limit above the table size acts as
  // the table size; a zero limit drops every put.
  assign lim_ok    = (live_limit != '0);
  assign lim_x     = CMP_W'(live_limit);
  assign cap_x     = CMP_W'(CAPACITY);
  assign eff_limit = (lim_x > cap_x) ? cap_x : lim_x;
  assign evict_now = (CMP_W'(used) >= eff_limit);
  assign bump_now  = found && (cmd_q == CMD_GET || lim_ok);
  assign ins_now   = !found && cmd_q == CMD_PUT && lim_ok;

  // After an eviction the victim's slot is free too; take the lower one.
  always_comb begin
    slot_now = free_idx;
    if (evict_now && !(free_any && free_idx < vic_idx)) begin
      slot_now = vic_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_bump <= 1'b0;
      p_ins  <= 1'b0;
    end else if (ctl.plan) begin
      p_bump <= bump_now;
      p_ins  <= ins_now;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.plan) begin
      p_evict <= evict_now;
      p_slot  <= slot_now;
      p_hit   <= found;
      p_rd    <= (found && cmd_q == CMD_GET) ? f_val : '0;
      p_ev    <= ins_now && evict_now;
    end
  end

  // Write-back pass. Bump: age entries newer than the touched one and
  // refresh it. Insert: drop the victim, close the gap it leaves by pulling
  // older ranks down by one, age every survivor by one and place the new
  // entry at rank zero.
  assign rank_dec = p_evict && rd_ent.rank > vic_rank;

  always_comb begin
    wr_ent  = rd_ent;
    wr_en   = 1'b0;
    vld_set = 1'b0;
    vld_clr = 1'b0;
    if (beat_vld && beat_sweep) begin
      if (p_ins) begin
        if (beat_idx == p_slot) begin
          wr_en        = 1'b1;
          vld_set      = 1'b1;
          wr_ent.key   = key_q;
          wr_ent.value = val_q;
          wr_ent.count = COUNT_W'(1);
          wr_ent.rank  = '0;
        end else if (bv && p_evict && beat_idx == vic_idx) begin
          vld_clr = 1'b1;
        end else if (bv) begin
          wr_en       = 1'b1;
          wr_ent.rank = rd_ent.rank - RANK_W'(rank_dec) + RANK_W'(1);
        end
      end else if (p_bump && bv) begin
        wr_en = 1'b1;
        if (beat_idx == f_idx) begin
          if (cmd_q == CMD_PUT) begin
            wr_ent.value = val_q;
          end
          if (rd_ent.count != COUNT_MAX) begin
            wr_ent.count = rd_ent.count + COUNT_W'(1);
          end
          wr_ent.rank = '0;
        end else if (rd_ent.rank < f_rank) begin
          wr_ent.rank = rd_ent.rank + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (vld_set) begin
      vld[beat_idx] <= 1'b1;
    end else if (vld_clr) begin
      vld[beat_idx] <= 1'b0;
    end
  end

  // Output register: load on finish, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      hit        <= p_hit;
      read_value <= p_rd;
      evicted    <= p_ev;
    end
  end

  `LFU_ASSERT_NOW(a_insert_has_slot, ctl.plan && ins_now, evict_now || free_any, "no free slot")
  `LFU_ASSERT_NOW(a_evict_not_hit, out_valid, !(hit && evicted), "eviction reported on a hit")
  `LFU_ASSERT_NOW(a_value_needs_hit, out_valid && read_value != '0, hit, "value without hit")
  `LFU_ASSERT_NEXT(a_finish_loads, ctl.finish, out_valid && !ctl.finish, "output not loaded")

endmodule

`default_nettype wire

@@ sim/lfu_cache_table_checker.sv @@
// Result checker for lfu_cache_table: predicts every result beat and compares it.
module lfu_cache_table_checker
  import lfu_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic               command,
  input  wire logic [KEY_W-1:0]   lookup_key,
  input  wire logic [VAL_W-1:0]   store_value,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               hit,
  input  wire logic [VAL_W-1:0]   read_value,
  input  wire logic               evicted,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_live_limit,
  output int unsigned             mismatch_count,
  output int unsigned             results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } lookup_reply_t;

  // Shadow copy of the cache table.
  logic               row_live  [CAPACITY];
  logic [KEY_W-1:0]   row_key   [CAPACITY];
  logic [VAL_W-1:0]   row_value [CAPACITY];
  logic [COUNT_W-1:0] row_uses  [CAPACITY];
  int unsigned        row_rank  [CAPACITY];  // 0 = most recently touched
  logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;

  lookup_reply_t      reply_q[$];
  int unsigned        errors = 0;

  function automatic void mark_recent(int idx);
    int unsigned prior;
    prior = row_rank[idx];
    for (int j = 0; j < CAPACITY; j++)
      if (row_live[j] && row_rank[j] < prior) row_rank[j]++;
    row_rank[idx] = 0;
  endfunction

  function automatic void count_use(int idx);
    if (row_uses[idx] != COUNT_MAX) row_uses[idx]++;
    mark_recent(idx);
  endfunction

  // Lowest count loses; among equal counts the stalest row loses.
  function automatic void evict_coldest();
    int victim;
    victim = -1;
    for (int j = 0; j < CAPACITY; j++)
      if (row_live[j] && (victim < 0 || row_uses[j] < row_uses[victim] ||
          (row_uses[j] == row_uses[victim] && row_rank[j] > row_rank[victim])))
        victim = j;
    if (victim >= 0) begin
      for (int j = 0; j < CAPACITY; j++)
        if (row_live[j] && row_rank[j] > row_rank[victim]) row_rank[j]--;
      row_live[victim] = 1'b0;
    end
  endfunction

  function automatic lookup_reply_t serve(logic cmd, logic [KEY_W-1:0] key,
                                          logic [VAL_W-1:0] value);
    lookup_reply_t r;
    int unsigned   room;
    int unsigned   occupied;
    int            found;
    int            free_row;
    r        = '0;
    occupied = 0;
    found    = -1;
    free_row = -1;
    room     = (limit_shadow > CAPACITY) ? CAPACITY : limit_shadow;
    for (int j = 0; j < CAPACITY; j++) begin
      if (row_live[j]) begin
        occupied++;
        if (found < 0 && row_key[j] == key) found = j;
      end
    end
    r.hit = (found >= 0);
    if (cmd == CMD_GET) begin
      if (found >= 0) begin
        r.read_value = row_value[found];
        count_use(found);
      end
    end else if (room != 0) begin
      if (found >= 0) begin
        row_value[found] = value;
        count_use(found);
      end else begin
        if (occupied >= room) begin
          evict_coldest();
          r.evicted = 1'b1;
        end
        for (int j = 0; j < CAPACITY; j++)
          if (!row_live[j] && free_row < 0) free_row = j;
        if (free_row >= 0) begin
          for (int j = 0; j < CAPACITY; j++)
            if (row_live[j]) row_rank[j]++;
          row_live[free_row]  = 1'b1;
          row_key[free_row]   = key;
          row_value[free_row] = value;
          row_uses[free_row]  = 1;
          row_rank[free_row]  = 0;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_reply_t want;
    if (rst) begin
      for (int j = 0; j < CAPACITY; j++) row_live[j] = 1'b0;
      limit_shadow = LIMIT_RESET;
      reply_q.delete();
      errors = 0;
    end else begin
      // Check first: a beat leaving now belongs to an earlier request.
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result beat with no request outstanding (hit %0b value %0h evicted %0b)",
                     $realtime, hit, read_value, evicted);
        end else begin
          want = reply_q.pop_front();
          if (want.hit !== hit || want.read_value !== read_value ||
              want.evicted !== evicted) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected hit %0b value %0h evicted %0b, got hit %0b value %0h evicted %0b",
                       $realtime, want.hit, want.read_value, want.evicted,
                       hit, read_value, evicted);
          end
        end
      end
      if (cfg_valid && cfg_ready) limit_shadow = cfg_live_limit;
      if (in_valid && !in_stall) reply_q.push_back(serve(command, lookup_key, store_value));
    end
    mismatch_count <= errors;
    results_owed   <= reply_q.size();
  end

endmodule

@@ sim/tb_lfu_cache_table.sv @@
// Testbench top for lfu_cache_table: clock, reset, stimulus, pacing and verdict.
module tb_lfu_cache_table;
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 162;
  localparam int POOL_SIZE      = 24;
  localparam int PRESSURE_PHASE = 5;    // receiver holds off long here
  localparam int DRAIN_PHASE    = 7;    // sender pauses mid-phase here
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;    // block returns to idle after its last beat
  localparam int TAIL_CYCLES    = 2 * CAPACITY + 8;

  // live_limit per random phase: full size, lowered below occupancy, above
  // capacity, zero, one, and a few in between.
  localparam logic [LIMIT_W-1:0] PHASE_LIMIT [PHASES] =
    '{5'd16, 5'd5, 5'd31, 5'd0, 5'd1, 5'd24, 5'd2, 5'd16, 5'd3, 5'd31, 5'd8, 5'd16};

  typedef enum logic [1:0] {
    PACE_FREE,      // no idling on either side
    PACE_SENDER,    // sender idles at random before each beat, 78 percent odds
    PACE_RECEIVER,  // receiver stalls at random, 78 percent odds
    PACE_BOTH       // both sides idle at random, 35 percent odds
  } pace_t;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               in_valid       = 1'b0;
  logic               command        = CMD_GET;
  logic [KEY_W-1:0]   lookup_key     = '0;
  logic [VAL_W-1:0]   store_value    = '0;
  logic               out_stall      = 1'b0;
  logic               cfg_valid      = 1'b0;
  logic [LIMIT_W-1:0] cfg_live_limit = '0;

  wire                in_stall;
  wire                out_valid;
  wire                hit;
  wire [VAL_W-1:0]    read_value;
  wire                evicted;
  wire                cfg_ready;

  int unsigned        mismatch_count;
  int unsigned        results_owed;

  pace_t              pace      = PACE_FREE;
  int                 phase_no  = 0;
  int unsigned        cycles    = 0;
  int unsigned        hold_left = 0;
  logic               hold_done = 1'b0;
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lfu_cache_table #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .lookup_key    (lookup_key),
    .store_value   (store_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .read_value    (read_value),
    .evicted       (evicted),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_live_limit(cfg_live_limit)
  );

  lfu_cache_table_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .lookup_key    (lookup_key),
    .store_value   (store_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .read_value    (read_value),
    .evicted       (evicted),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_live_limit(cfg_live_limit),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result receiver. Stall at random per the current pace; once, at the
  // start of the pressure phase, hold off for a long stretch so that the
  // output register and the item behind it fill up and in_stall rises.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (phase_no == PRESSURE_PHASE && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (pace == PACE_RECEIVER && $urandom_range(99) < 78) ||
                   (pace == PACE_BOTH && $urandom_range(99) < 35);
    end
  end

  // Offer one input beat. Idle first per the pace, then hold the payload
  // steady until the beat is taken.
  task automatic send_beat(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    while ((pace == PACE_SENDER && $urandom_range(99) < 78) ||
           (pace == PACE_BOTH && $urandom_range(99) < 35)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    lookup_key  <= key;
    store_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has left the block,
  // then wait out the settle time so it can finish its write-back.
  task automatic drain(int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    int unsigned room;
    int unsigned span;
    int unsigned pick;
    logic [31:0] draw;

    // Keys 0 and all-ones are always in the pool; the rest are random.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset limit of 16.
    send_beat(CMD_GET, '0, '0);                // miss on an empty table
    send_beat(CMD_PUT, '0, '0);                // lowest key, lowest value
    send_beat(CMD_PUT, '1, '1);                // highest key, highest value
    send_beat(CMD_GET, '1, '0);
    send_beat(CMD_GET, '0, '1);                // store_value is ignored on a get
    send_beat(CMD_PUT, '0, '1);                // update a present key
    send_beat(CMD_GET, '0, '0);
    send_beat(CMD_GET, 32'h1234_5678, '0);     // miss on a partly filled table
    for (int i = 2; i < CAPACITY; i++) begin   // fill the table
      draw = $urandom;
      send_beat(CMD_PUT, key_pool[i], draw[VAL_W-1:0]);
    end
    send_beat(CMD_GET, key_pool[2], '0);       // warm one count-1 row
    draw = $urandom;
    send_beat(CMD_PUT, key_pool[CAPACITY], draw[VAL_W-1:0]);     // evict, reuse freed row
    send_beat(CMD_PUT, key_pool[CAPACITY + 1], ~draw[VAL_W-1:0]); // evict the next coldest
    send_beat(CMD_GET, key_pool[3], '0);       // evicted key now misses

    // Random phases. Reconfigure only once the block has gone idle.
    for (int p = 1; p <= PHASES; p++) begin
      drain(SETTLE_CYCLES);
      phase_no       <= p;
      pace           <= pace_t'((p - 1) % 4);
      cfg_live_limit <= PHASE_LIMIT[p - 1];
      cfg_valid      <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;

      // Size the working set of keys to the limit so hits, updates and
      // evictions all stay frequent.
      room = (PHASE_LIMIT[p - 1] > CAPACITY) ? CAPACITY : PHASE_LIMIT[p - 1];
      span = (room == 0) ? 8 : room + room / 2 + 2;
      if (span > POOL_SIZE) span = POOL_SIZE;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == DRAIN_PHASE && i == PHASE_ITEMS / 2) drain(0);
        draw = $urandom;
        pick = $urandom_range(99);
        if (pick < 45)
          send_beat(CMD_GET, key_pool[$urandom_range(span - 1)], draw[VAL_W-1:0]);
        else if (pick < 85)
          send_beat(CMD_PUT, key_pool[$urandom_range(span - 1)], draw[VAL_W-1:0]);
        else if (pick < 95)
          send_beat(CMD_PUT, $urandom, draw[VAL_W-1:0]);   // almost surely a new key
        else
          send_beat(CMD_GET, $urandom, draw[VAL_W-1:0]);   // almost surely a miss
      end
    end

    // Let the last results out, then watch a while for stray beats.
    drain(TAIL_CYCLES);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
